@@ hdl/hapd_pkg.sv @@
// hapd_pkg: shared types and constants for the hex address list parser
// result kinds, controller states and the controller/datapath command and status
// no dependencies
package hapd_pkg;

    localparam int MAX_ADDRESSES_DEF = 64;
    localparam int ADDRESS_BITS_DEF  = 64;
    localparam int OUT_ADDRESS_BITS  = 64;

    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_F = 8'h46;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_F = 8'h66;
    localparam logic [7:0] CHAR_UPPER_X = 8'h58;
    localparam logic [7:0] CHAR_LOWER_X = 8'h78;
    localparam logic [3:0] LETTER_OFFSET = 4'd9;

    typedef enum logic [1:0] {
        KIND_ADDR    = 2'd0,
        KIND_DONE    = 2'd1,
        KIND_INVALID = 2'd2,
        KIND_FULL    = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FINISH,
        S_READ,
        S_COMPARE,
        S_INSERT,
        S_INVALID,
        S_NEXT,
        S_DONE
    } state_t;

    typedef struct packed {
        logic  load;
        logic  feed;
        logic  tok_clear;
        logic  body_clear;
        logic  search_start;
        logic  search_step;
        logic  store_write;
        logic  set_discard;
        logic  emit;
        kind_t emit_kind;
    } dp_cmd_t;

    typedef struct packed {
        logic in_sep;
        logic in_end;
        logic sep_seen;
        logic end_seen;
        logic discarding;
        logic tok_bad;
        logic count_zero;
        logic count_full;
        logic match;
        logic last_entry;
        logic out_free;
    } dp_status_t;

endpackage

@@ hdl/hapd_if.sv @@
// hapd_body_if and hapd_result_if: valid/ready channels of the parser
// no dependencies
interface hapd_body_if;
    logic       valid;
    logic       ready;
    logic [7:0] body_byte;
    logic       body_end;

    modport source (output valid, output body_byte, output body_end, input ready);
    modport sink   (input valid, input body_byte, input body_end, output ready);
endinterface

interface hapd_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [63:0] address_value;
    logic        final_result;

    modport source (output valid, output kind, output address_value, output final_result,
                    input ready);
    modport sink   (input valid, input kind, input address_value, input final_result,
                    output ready);
endinterface

@@ hdl/hapd_dpath.sv @@
// hapd_dpath: token accumulator, address store, duplicate compare and result register
// depends on hapd_pkg
module hapd_dpath
    import hapd_pkg::*;
#(
    parameter int MAX_ADDRESSES = MAX_ADDRESSES_DEF,
    parameter int ADDRESS_BITS  = ADDRESS_BITS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [7:0]                  body_byte,
    input  logic                        body_end,
    input  dp_cmd_t                     cmd,
    output dp_status_t                  status,
    input  logic                        result_ready,
    output logic                        result_valid,
    output logic [1:0]                  kind,
    output logic [OUT_ADDRESS_BITS-1:0] address_value,
    output logic                        final_result
);

    localparam int IW = (MAX_ADDRESSES > 1) ? $clog2(MAX_ADDRESSES) : 1;
    localparam int CW = $clog2(MAX_ADDRESSES + 1);

    logic [1:0]              pos_reg, pos_next;
    logic                    fwz_reg, fwz_next;
    logic [ADDRESS_BITS-1:0] acc_reg, acc_next;
    logic                    bad_reg, bad_next;
    logic                    discard_reg, discard_next;
    logic [CW-1:0]           count_reg, count_next;
    logic [CW-1:0]           idx_reg, idx_next;
    logic                    sep_reg, end_reg;
    logic [ADDRESS_BITS-1:0] rd_data_reg;
    logic [ADDRESS_BITS-1:0] store_mem [MAX_ADDRESSES];

    logic                        out_valid_reg;
    kind_t                       out_kind_reg;
    logic [OUT_ADDRESS_BITS-1:0] out_addr_reg;
    logic                        out_final_reg;

    logic [3:0] nib;
    logic       nib_ok;
    logic       is_x;
    logic       skip;

    // hex digit decode
    always_comb
    begin
        nib    = body_byte[3:0];
        nib_ok = 1'b0;
        if (body_byte >= CHAR_ZERO && body_byte <= CHAR_NINE)
        begin
            nib_ok = 1'b1;
        end
        else if ((body_byte >= CHAR_LOWER_A && body_byte <= CHAR_LOWER_F) ||
                 (body_byte >= CHAR_UPPER_A && body_byte <= CHAR_UPPER_F))
        begin
            nib    = body_byte[3:0] + LETTER_OFFSET;
            nib_ok = 1'b1;
        end
    end

    assign is_x = (body_byte == CHAR_LOWER_X) || (body_byte == CHAR_UPPER_X);
    assign skip = (pos_reg == 2'd1) && fwz_reg && is_x;

    always_comb
    begin
        pos_next     = pos_reg;
        fwz_next     = fwz_reg;
        acc_next     = acc_reg;
        bad_next     = bad_reg;
        discard_next = discard_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;

        if (cmd.tok_clear || cmd.body_clear)
        begin
            pos_next = 2'd0;
            fwz_next = 1'b0;
            acc_next = '0;
            bad_next = 1'b0;
        end
        else if (cmd.feed)
        begin
            if (pos_reg != 2'd3)
            begin
                pos_next = pos_reg + 2'd1;
            end
            if (pos_reg == 2'd0)
            begin
                fwz_next = (body_byte == CHAR_ZERO);
            end
            else if (!skip)
            begin
                fwz_next = 1'b0;
            end
            if (!skip && !bad_reg)
            begin
                if (!nib_ok || (acc_reg[ADDRESS_BITS-1 -: 4] != 4'd0))
                begin
                    bad_next = 1'b1;
                end
                else
                begin
                    acc_next = {acc_reg[ADDRESS_BITS-5:0], nib};
                end
            end
        end

        if (cmd.set_discard)
        begin
            discard_next = 1'b1;
        end
        if (cmd.store_write)
        begin
            count_next = count_reg + CW'(1);
        end
        if (cmd.body_clear)
        begin
            discard_next = 1'b0;
            count_next   = '0;
        end

        if (cmd.search_start)
        begin
            idx_next = '0;
        end
        else if (cmd.search_step)
        begin
            idx_next = idx_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= 2'd0;
            fwz_reg       <= 1'b0;
            acc_reg       <= '0;
            bad_reg       <= 1'b0;
            discard_reg   <= 1'b0;
            count_reg     <= '0;
            idx_reg       <= '0;
            sep_reg       <= 1'b0;
            end_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg     <= pos_next;
            fwz_reg     <= fwz_next;
            acc_reg     <= acc_next;
            bad_reg     <= bad_next;
            discard_reg <= discard_next;
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            if (cmd.load)
            begin
                sep_reg <= (body_byte == CHAR_PLUS);
                end_reg <= body_end;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_kind_reg  <= cmd.emit_kind;
            out_final_reg <= (cmd.emit_kind != KIND_ADDR);
            if (cmd.emit_kind == KIND_ADDR)
            begin
                out_addr_reg <= OUT_ADDRESS_BITS'(acc_reg);
            end
            else
            begin
                out_addr_reg <= '0;
            end
        end
    end

    // address store
    always_ff @(posedge clk)
    begin
        if (cmd.store_write)
        begin
            store_mem[count_reg[IW-1:0]] <= acc_reg;
        end
        rd_data_reg <= store_mem[idx_reg[IW-1:0]];
    end

    assign status.in_sep     = (body_byte == CHAR_PLUS);
    assign status.in_end     = body_end;
    assign status.sep_seen   = sep_reg;
    assign status.end_seen   = end_reg;
    assign status.discarding = discard_reg;
    assign status.tok_bad    = bad_reg || (pos_reg == 2'd0) ||
                               ((pos_reg == 2'd2) && fwz_reg) || (acc_reg == '0);
    assign status.count_zero = (count_reg == '0);
    assign status.count_full = (count_reg == CW'(MAX_ADDRESSES));
    assign status.match      = (rd_data_reg == acc_reg);
    assign status.last_entry = ((idx_reg + CW'(1)) == count_reg);
    assign status.out_free   = !out_valid_reg || result_ready;

    assign result_valid  = out_valid_reg;
    assign kind          = out_kind_reg;
    assign address_value = out_addr_reg;
    assign final_result  = out_final_reg;

endmodule

@@ hdl/hapd_ctrl.sv @@
// hapd_ctrl: sequencer for byte intake, token finish, store search and result issue
// depends on hapd_pkg
module hapd_ctrl
    import hapd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       body_valid,
    output logic       body_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t state_reg, state_next;
    logic   pass_reg, pass_next;

    always_comb
    begin
        state_next = state_reg;
        pass_next  = pass_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (body_valid && !status.discarding &&
                    (status.in_sep || status.in_end))
                begin
                    state_next = S_FINISH;
                    pass_next  = 1'b0;
                end
            end
            S_FINISH:
            begin
                if (status.tok_bad)
                begin
                    state_next = S_INVALID;
                end
                else if (status.count_zero)
                begin
                    state_next = S_INSERT;
                end
                else
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_COMPARE;
            end
            S_COMPARE:
            begin
                if (status.match)
                begin
                    state_next = S_NEXT;
                end
                else if (status.last_entry)
                begin
                    state_next = S_INSERT;
                end
                else
                begin
                    state_next = S_READ;
                end
            end
            S_INSERT, S_INVALID:
            begin
                if (status.out_free)
                begin
                    state_next = S_NEXT;
                end
            end
            S_NEXT:
            begin
                if (status.discarding)
                begin
                    state_next = S_IDLE;
                end
                else if (status.sep_seen && status.end_seen && !pass_reg)
                begin
                    state_next = S_FINISH;
                    pass_next  = 1'b1;
                end
                else if (status.end_seen)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd           = '0;
        cmd.emit_kind = KIND_ADDR;
        body_ready    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                body_ready = 1'b1;
                if (body_valid)
                begin
                    cmd.load = 1'b1;
                    if (status.discarding)
                    begin
                        cmd.body_clear = status.in_end;
                    end
                    else
                    begin
                        cmd.feed = !status.in_sep;
                    end
                end
            end
            S_FINISH:
            begin
                cmd.search_start = 1'b1;
            end
            S_READ:
            begin
            end
            S_COMPARE:
            begin
                cmd.search_step = !status.match && !status.last_entry;
            end
            S_INSERT:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.count_full)
                    begin
                        cmd.emit_kind   = KIND_FULL;
                        cmd.set_discard = 1'b1;
                    end
                    else
                    begin
                        cmd.emit_kind   = KIND_ADDR;
                        cmd.store_write = 1'b1;
                    end
                end
            end
            S_INVALID:
            begin
                if (status.out_free)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_kind   = KIND_INVALID;
                    cmd.set_discard = 1'b1;
                end
            end
            S_NEXT:
            begin
                cmd.tok_clear  = 1'b1;
                cmd.body_clear = status.discarding && status.end_seen;
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.emit       = 1'b1;
                    cmd.emit_kind  = KIND_DONE;
                    cmd.body_clear = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pass_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pass_reg  <= pass_next;
        end
    end

endmodule

@@ hdl/hex_address_list_parser_dedup.sv @@
// channel  direction  beat payload
// body     in         body_byte[7:0], body_end
// result   out        kind[1:0], address_value[63:0], final_result
//
// a plain byte is taken in idle; a '+' or the last byte runs finish, then invalid or a
// read and a compare per stored address searched (one store read port, one entry per
// compare), insert unless matched, next; a '+' on the last byte runs the finish twice
// reset is asynchronous, active low, and clears control state; the store is not cleared
// a stalled result holds the sequencer in its issue state; a beat is accepted only in idle
// depends on hapd_pkg, hapd_if, hapd_ctrl, hapd_dpath
module hex_address_list_parser_dedup
    import hapd_pkg::*;
#(
    parameter int MAX_ADDRESSES = MAX_ADDRESSES_DEF,
    parameter int ADDRESS_BITS  = ADDRESS_BITS_DEF
)
(
    input logic               clk,
    input logic               rst_n,
    hapd_body_if.sink         body,
    hapd_result_if.source     result
);

    dp_cmd_t    cmd;
    dp_status_t status;

    hapd_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .body_valid (body.valid),
        .body_ready (body.ready),
        .status     (status),
        .cmd        (cmd)
    );

    hapd_dpath #(
        .MAX_ADDRESSES (MAX_ADDRESSES),
        .ADDRESS_BITS  (ADDRESS_BITS)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .body_byte     (body.body_byte),
        .body_end      (body.body_end),
        .cmd           (cmd),
        .status        (status),
        .result_ready  (result.ready),
        .result_valid  (result.valid),
        .kind          (result.kind),
        .address_value (result.address_value),
        .final_result  (result.final_result)
    );

endmodule

@@ tb/tb_hex_address_list_parser_dedup.sv @@
// tb_hex_address_list_parser_dedup: self-checking bench for the hex address list parser
// drives '+'-separated hex bodies byte by byte and predicts every result beat in the bench
// depends on hapd_pkg, hapd_if and hex_address_list_parser_dedup
module tb_hex_address_list_parser_dedup;
    import hapd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        kind_t       kind;
        logic [63:0] address_value;
        logic        final_result;
    } parse_result_t;

    logic clk;
    logic rst_n;

    hapd_body_if   body_ch ();
    hapd_result_if result_ch ();

    hex_address_list_parser_dedup uut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .body   (body_ch),
        .result (result_ch)
    );

    parse_result_t expected_results [$];
    logic [7:0]    body_q [$];

    logic          idle_en;
    int            hold_cycles;
    int            error_count;
    int            beats_in;
    int            bodies_in;
    int            kind_hits [4];
    logic [63:0]   used_addr [$];

    // bench copy of the parser state
    logic          skip_body;
    logic [1:0]    tok_len;
    logic          tok_lead_zero;
    logic [63:0]   tok_value;
    logic          tok_bad;
    logic [63:0]   seen_addr [MAX_ADDRESSES_DEF];
    int            seen_count;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    initial
    begin
        #8ms;
        $display("tb_hex_address_list_parser_dedup NOT OK");
        $finish;
    end

    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            result_ch.ready <= 1'b0;
            hold_cycles = hold_cycles - 1;
        end
        else
        begin
            result_ch.ready <= !idle_en || ($urandom_range(99) >= 19);
        end
    end

    function automatic int nibble_of(input logic [7:0] c);
        if (c >= CHAR_ZERO && c <= CHAR_NINE)
            return int'(c) - int'(CHAR_ZERO);
        if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F)
            return int'(c) - int'(CHAR_LOWER_A) + 10;
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F)
            return int'(c) - int'(CHAR_UPPER_A) + 10;
        return -1;
    endfunction

    task automatic push_result(input kind_t k, input logic [63:0] v, input logic fin);
        parse_result_t r;
        r.kind = k;
        r.address_value = v;
        r.final_result = fin;
        expected_results = {expected_results, r};
    endtask

    task automatic clear_token();
        tok_len = 2'd0;
        tok_lead_zero = 1'b0;
        tok_value = 64'd0;
        tok_bad = 1'b0;
    endtask

    task automatic take_char(input logic [7:0] c);
        logic [1:0] pos;
        int         v;
        pos = tok_len;
        tok_len = (pos < 2'd3) ? pos + 2'd1 : 2'd3;
        if (pos == 2'd0)
            tok_lead_zero = (c == CHAR_ZERO);
        else if (pos == 2'd1 && tok_lead_zero && (c == CHAR_LOWER_X || c == CHAR_UPPER_X))
            return;
        else
            tok_lead_zero = 1'b0;
        if (tok_bad)
            return;
        v = nibble_of(c);
        if (v < 0 || tok_value[63:60] != 4'd0)
        begin
            tok_bad = 1'b1;
            return;
        end
        tok_value = {tok_value[59:0], v[3:0]};
    endtask

    task automatic close_token();
        logic        bad;
        logic        dup;
        logic [63:0] addr;
        bad = tok_bad || tok_len == 2'd0 || (tok_len == 2'd2 && tok_lead_zero) ||
              tok_value == 64'd0;
        addr = tok_value;
        clear_token();
        if (bad)
        begin
            push_result(KIND_INVALID, 64'd0, 1'b1);
            skip_body = 1'b1;
            return;
        end
        dup = 1'b0;
        for (int i = 0; i < seen_count; i++)
        begin
            if (seen_addr[i] == addr)
                dup = 1'b1;
        end
        if (dup)
            return;
        if (seen_count >= MAX_ADDRESSES_DEF)
        begin
            push_result(KIND_FULL, 64'd0, 1'b1);
            skip_body = 1'b1;
            return;
        end
        seen_addr[seen_count] = addr;
        seen_count++;
        push_result(KIND_ADDR, addr, 1'b0);
    endtask

    task automatic predict_beat(input logic [7:0] b, input logic last);
        logic sep;
        sep = (b == CHAR_PLUS);
        if (!skip_body)
        begin
            if (!sep)
                take_char(b);
            if (sep || last)
                close_token();
            if (sep && last && !skip_body)
                close_token();
            if (last && !skip_body)
                push_result(KIND_DONE, 64'd0, 1'b1);
        end
        if (last)
        begin
            skip_body = 1'b0;
            clear_token();
            seen_count = 0;
        end
    endtask

    task automatic check_result();
        parse_result_t exp_r;
        if (expected_results.size() == 0)
        begin
            $error("unexpected result beat: kind %0d address_value %h",
                   result_ch.kind, result_ch.address_value);
            error_count++;
            return;
        end
        exp_r = expected_results.pop_front();
        kind_hits[exp_r.kind]++;
        if (result_ch.kind !== exp_r.kind)
        begin
            $error("kind: expected %0d, got %0d", exp_r.kind, result_ch.kind);
            error_count++;
        end
        if (result_ch.address_value !== exp_r.address_value)
        begin
            $error("address_value: expected %h, got %h",
                   exp_r.address_value, result_ch.address_value);
            error_count++;
        end
        if (result_ch.final_result !== exp_r.final_result)
        begin
            $error("final_result: expected %0b, got %0b",
                   exp_r.final_result, result_ch.final_result);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && body_ch.valid && body_ch.ready)
        begin
            beats_in++;
            if (body_ch.body_end)
                bodies_in++;
            predict_beat(body_ch.body_byte, body_ch.body_end);
        end
        if (rst_n && result_ch.valid && result_ch.ready)
            check_result();
    end

    // called and returns at a falling edge
    task automatic send_beat(input logic [7:0] b, input logic last);
        if (idle_en)
        begin
            while ($urandom_range(99) < 19)
            begin
                body_ch.valid <= 1'b0;
                @(negedge clk);
            end
        end
        body_ch.valid <= 1'b1;
        body_ch.body_byte <= b;
        body_ch.body_end <= last;
        @(posedge clk);
        while (!body_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic put_char(input logic [7:0] c);
        body_q = {body_q, c};
    endtask

    task automatic send_body();
        for (int i = 0; i < body_q.size(); i++)
            send_beat(body_q[i], i == body_q.size() - 1);
        body_q.delete();
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++)
            put_char(txt[i]);
        send_body();
    endtask

    task automatic wait_drained();
        body_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10)
            return CHAR_ZERO + 8'(nib);
        return ($urandom_range(1) ? CHAR_UPPER_A : CHAR_LOWER_A) + 8'(nib - 4'd10);
    endfunction

    function automatic int hex_len(input logic [63:0] v);
        int n;
        n = 1;
        while (n < 16 && (v >> (4 * n)) != 64'd0)
            n++;
        return n;
    endfunction

    task automatic put_hex(input logic [63:0] v, input int ndig);
        logic [3:0] nib;
        for (int i = ndig - 1; i >= 0; i--)
        begin
            nib = (i < 16) ? v[4 * i +: 4] : 4'd0;
            put_char(hex_char(nib));
        end
    endtask

    task automatic put_prefix();
        put_char(CHAR_ZERO);
        put_char($urandom_range(1) ? CHAR_UPPER_X : CHAR_LOWER_X);
    endtask

    function automatic logic [63:0] random_addr();
        int          ndig;
        logic [63:0] v;
        ndig = $urandom_range(1, 16);
        v = {$urandom, $urandom};
        v = v >> (64 - 4 * ndig);
        if (v == 64'd0)
            v = 64'd1;
        return v;
    endfunction

    task automatic gen_token(input int noise_pct);
        logic [63:0] v;
        logic [7:0]  c;
        if ($urandom_range(99) < noise_pct)
        begin
            case ($urandom_range(5))
                0: ;
                1:
                begin
                    if ($urandom_range(1))
                        put_hex(random_addr(), $urandom_range(1, 4));
                    do
                        c = 8'($urandom_range(255));
                    while (nibble_of(c) >= 0 || c == CHAR_PLUS);
                    put_char(c);
                    if ($urandom_range(1))
                        put_hex(random_addr(), $urandom_range(1, 3));
                end
                2:
                begin
                    put_hex(64'($urandom_range(1, 15)), 1);
                    put_hex({$urandom, $urandom}, 16);
                end
                3:
                begin
                    if ($urandom_range(1))
                        put_prefix();
                    put_hex(64'd0, $urandom_range(1, 3));
                end
                4: put_prefix();
                default:
                begin
                    put_hex(random_addr(), $urandom_range(1, 3));
                    put_char($urandom_range(1) ? CHAR_UPPER_X : CHAR_LOWER_X);
                end
            endcase
        end
        else
        begin
            if (used_addr.size() != 0 && $urandom_range(99) < 25)
                v = used_addr[$urandom_range(used_addr.size() - 1)];
            else
                v = random_addr();
            used_addr = {used_addr, v};
            if (used_addr.size() > 40)
                void'(used_addr.pop_front());
            if ($urandom_range(99) < 30)
                put_prefix();
            put_hex(v, hex_len(v) + (($urandom_range(9) == 0) ? $urandom_range(1, 2) : 0));
        end
    endtask

    task automatic gen_body(input int ntok, input int noise_pct);
        if ($urandom_range(99) < 3)
            put_char(CHAR_PLUS);
        for (int t = 0; t < ntok; t++)
        begin
            if (t > 0)
                put_char(CHAR_PLUS);
            gen_token(noise_pct);
        end
        if ($urandom_range(99) < 5)
            put_char(CHAR_PLUS);
        if (body_q.size() == 0)
            put_char(CHAR_PLUS);
        send_body();
    endtask

    task automatic test_directed_cases();
        send_text("0x1+1");
        send_text("+");
        send_text("0X");
        send_text("1x");
        send_text("0");
        put_char(8'h00);
        send_body();
        put_char(8'hFF);
        send_body();
        send_text("a+");
        send_text("F+2");
        send_text("g+1");
    endtask

    task automatic test_value_limits();
        send_text("FfFfffffffffffff+10000000000000000");
        send_text("0x0000000000000000001+0x000+5");
        send_text("x5");
        send_text("0xx1");
        send_text("8000000000000000+1+8000000000000000");
    endtask

    task automatic test_store_limit();
        logic [63:0] base;
        logic [63:0] addr;
        int          stride;
        for (int lap = 0; lap < 2; lap++)
        begin
            base = 64'($urandom_range(1, 4000));
            stride = $urandom_range(1, 9);
            for (int i = 0; i < MAX_ADDRESSES_DEF; i++)
            begin
                addr = base + 64'(i * stride);
                if (i > 0)
                    put_char(CHAR_PLUS);
                put_hex(addr, hex_len(addr));
            end
            // a repeat is still fine once the store is full
            put_char(CHAR_PLUS);
            put_hex(base, hex_len(base));
            if (lap == 1)
            begin
                addr = base + 64'(MAX_ADDRESSES_DEF * stride);
                put_char(CHAR_PLUS);
                put_hex(addr, hex_len(addr));
                put_char(CHAR_PLUS);
                put_hex(random_addr(), 3);
            end
            send_body();
        end
    endtask

    task automatic test_no_idle();
        int stop_at;
        idle_en = 1'b0;
        stop_at = beats_in + 200;
        while (beats_in < stop_at)
            gen_body($urandom_range(1, 8), 10);
        idle_en = 1'b1;
    endtask

    task automatic test_backpressure();
        wait_drained();
        @(posedge clk);
        hold_cycles = 400;
        @(negedge clk);
        gen_body(14, 0);
        gen_body(3, 0);
        wait_drained();
    endtask

    task automatic test_random_bodies();
        while (beats_in < 1700)
        begin
            if ($urandom_range(99) < 80)
                gen_body($urandom_range(1, 6), 12);
            else
                gen_body($urandom_range(7, 24), 6);
        end
        wait_drained();
    endtask

    initial
    begin
        rst_n = 1'b0;
        body_ch.valid = 1'b0;
        body_ch.body_byte = 8'd0;
        body_ch.body_end = 1'b0;
        result_ch.ready = 1'b0;
        idle_en = 1'b1;
        hold_cycles = 0;
        error_count = 0;
        beats_in = 0;
        bodies_in = 0;
        kind_hits = '{default: 0};
        skip_body = 1'b0;
        seen_count = 0;
        clear_token();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed_cases();
        test_value_limits();
        test_store_limit();
        test_no_idle();
        test_backpressure();
        test_random_bodies();

        $display("%0d body beats in %0d bodies sent, including full store and stalled output",
                 beats_in, bodies_in);
        $display("results: %0d addresses, %0d done, %0d invalid, %0d too many",
                 kind_hits[KIND_ADDR], kind_hits[KIND_DONE], kind_hits[KIND_INVALID],
                 kind_hits[KIND_FULL]);
        if (error_count == 0)
            $display("tb_hex_address_list_parser_dedup OK");
        else
            $display("tb_hex_address_list_parser_dedup NOT OK");
        $finish;
    end

endmodule
